@@ rtl/core/wgo_pkg.sv @@
// Shared types, constants and tables of the wheel and gyro odometry block.
package wgo_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_DEPTH = 24;
	localparam int STEP_W = $clog2(ATAN_DEPTH);
	localparam int NUM_PART = 8;

	localparam int OP_W = 2;
	localparam int IN_DATA_W = 176;
	localparam int OUT_DATA_W = 112;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_SET = 2'd1;
	localparam logic [OP_W-1:0] OP_HEADING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd2;

	localparam logic signed [33:0] PI_Q28 = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;
	localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

	localparam logic signed [52:0] POS_MAX = 53'sd140737488355327;
	localparam logic signed [52:0] POS_MIN = -53'sd140737488355328;

	localparam logic [27:0] ATAN_Q28 [ATAN_DEPTH] = '{
		28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
		28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
		28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
		28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64, 28'd32
	};

	typedef enum logic [3:0] {
		MUL_TX = 4'd0,
		MUL_TY = 4'd1,
		MUL_XC_HI = 4'd2,
		MUL_XC_LO = 4'd3,
		MUL_YS_HI = 4'd4,
		MUL_YS_LO = 4'd5,
		MUL_XS_HI = 4'd6,
		MUL_XS_LO = 4'd7,
		MUL_YC_HI = 4'd8,
		MUL_YC_LO = 4'd9
	} mul_sel_t;

	typedef struct packed {
		logic load;
		logic cordic_en;
		logic [STEP_W-1:0] step;
		logic mul_en;
		mul_sel_t mul_sel;
		logic commit;
	} wgo_cmd_t;

	typedef struct packed {
		logic op_update;
		logic out_free;
	} wgo_stat_t;

endpackage

@@ rtl/core/wgo_ctrl.sv @@
// Controller state machine that sequences the CORDIC and the shared multiplier.
module wgo_ctrl #(
	parameter int CORDIC_STEPS = wgo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  wgo_pkg::wgo_stat_t  stat,
	output wgo_pkg::wgo_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CORDIC = 4'b0010,
		ST_PROD = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	localparam logic [wgo_pkg::STEP_W-1:0] CORDIC_LAST = wgo_pkg::STEP_W'(CORDIC_STEPS - 1);
	localparam logic [wgo_pkg::STEP_W-1:0] PROD_LAST = wgo_pkg::STEP_W'(wgo_pkg::NUM_PART);

	state_t state_q, state_d;
	logic [wgo_pkg::STEP_W-1:0] cnt_q, cnt_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					state_d = stat.op_update ? ST_CORDIC : ST_FINISH;
				end
			end
			ST_CORDIC: begin
				cmd.cordic_en = 1'b1;
				cmd.step = cnt_q;
				if (cnt_q == '0) begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = wgo_pkg::MUL_TX;
				end else if (cnt_q == wgo_pkg::STEP_W'(1)) begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = wgo_pkg::MUL_TY;
				end
				if (cnt_q == CORDIC_LAST) begin
					cnt_d = '0;
					state_d = ST_PROD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PROD: begin
				if (cnt_q < PROD_LAST) begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = wgo_pkg::mul_sel_t'(4'(wgo_pkg::MUL_XC_HI) + {1'b0, cnt_q[2:0]});
				end
				if (cnt_q == PROD_LAST) begin
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

@@ rtl/core/wgo_dpath.sv @@
// Datapath with configuration, odometry state, CORDIC, shared multiplier and result register.
module wgo_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [wgo_pkg::IN_DATA_W-1:0]         s_tdata,
	input  logic [wgo_pkg::OP_W-1:0]              s_tuser,
	input  logic                                  cfg_valid,
	input  logic [wgo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wgo_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  m_tready,
	output logic                                  m_tvalid,
	output logic [wgo_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wgo_pkg::wgo_cmd_t                     cmd,
	output wgo_pkg::wgo_stat_t                    stat
);

	logic signed [31:0] in_cx, in_cy;
	logic signed [15:0] in_imu;
	logic signed [47:0] in_setx, in_sety;

	logic signed [15:0] offset_q;
	logic [31:0] scale_x_q, scale_y_q;
	logic signed [31:0] last_x_q, last_y_q;
	logic signed [47:0] world_x_q, world_y_q;
	logic signed [15:0] head_q;

	logic [wgo_pkg::OP_W-1:0] op_q;
	logic signed [31:0] cx_q, cy_q;
	logic signed [47:0] setx_q, sety_q;
	logic signed [15:0] hd_q;
	logic [31:0] mx_q, my_q;
	logic sx_q, sy_q;
	logic signed [32:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic flip_q;
	logic [47:0] rx_q, ry_q;
	logic [63:0] prod_q;
	logic [79:0] pacc_q;
	logic signed [52:0] sum_x_q, sum_y_q;
	logic acc_en_q;
	wgo_pkg::mul_sel_t acc_sel_q;
	logic out_valid_q;
	logic [wgo_pkg::OUT_DATA_W-1:0] out_q;

	logic signed [16:0] hsum;
	logic signed [15:0] hsat;
	logic signed [32:0] diff_x, diff_y;
	logic signed [33:0] zh, z1, z2, z3;
	logic flip0;
	logic signed [32:0] xs, ys;
	logic signed [33:0] atan_v;
	logic [31:0] cmag, smag;
	logic [31:0] op_a, op_b;
	logic [63:0] rnd;
	logic [79:0] full, qr;
	logic [49:0] q;
	logic term_neg, term_to_y;
	logic signed [52:0] term;
	logic signed [47:0] sat_x, sat_y;
	logic signed [47:0] nx, ny;
	logic signed [15:0] nh;

	assign in_cx = s_tdata[31:0];
	assign in_cy = s_tdata[63:32];
	assign in_imu = s_tdata[79:64];
	assign in_setx = s_tdata[127:80];
	assign in_sety = s_tdata[175:128];

	assign stat.op_update = (s_tuser == wgo_pkg::OP_UPDATE);
	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	always_comb begin
		hsum = 17'(in_imu) + 17'(offset_q);
		if (hsum > 17'sd32767) begin
			hsat = 16'sh7fff;
		end else if (hsum < -17'sd32768) begin
			hsat = -16'sh8000;
		end else begin
			hsat = hsum[15:0];
		end
		diff_x = 33'(last_x_q) - 33'(in_cx);
		diff_y = 33'(in_cy) - 33'(last_y_q);
		zh = {{2{hsat[15]}}, hsat, 16'b0};
		z1 = (zh > wgo_pkg::PI_Q28) ? zh - wgo_pkg::TWO_PI_Q28 : zh;
		z2 = (z1 < -wgo_pkg::PI_Q28) ? z1 + wgo_pkg::TWO_PI_Q28 : z1;
		flip0 = 1'b0;
		z3 = z2;
		if (z2 > wgo_pkg::HALF_PI_Q28) begin
			z3 = z2 - wgo_pkg::PI_Q28;
			flip0 = 1'b1;
		end else if (z2 < -wgo_pkg::HALF_PI_Q28) begin
			z3 = z2 + wgo_pkg::PI_Q28;
			flip0 = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> cmd.step;
		ys = y_q >>> cmd.step;
		atan_v = 34'(wgo_pkg::ATAN_Q28[cmd.step]);
		cmag = x_q[32] ? 32'(-x_q) : x_q[31:0];
		smag = y_q[32] ? 32'(-y_q) : y_q[31:0];
	end

	always_comb begin
		unique case (cmd.mul_sel)
			wgo_pkg::MUL_TX: begin op_a = mx_q; op_b = scale_x_q; end
			wgo_pkg::MUL_TY: begin op_a = my_q; op_b = scale_y_q; end
			wgo_pkg::MUL_XC_HI: begin op_a = {8'b0, rx_q[47:24]}; op_b = cmag; end
			wgo_pkg::MUL_XC_LO: begin op_a = {8'b0, rx_q[23:0]}; op_b = cmag; end
			wgo_pkg::MUL_YS_HI: begin op_a = {8'b0, ry_q[47:24]}; op_b = smag; end
			wgo_pkg::MUL_YS_LO: begin op_a = {8'b0, ry_q[23:0]}; op_b = smag; end
			wgo_pkg::MUL_XS_HI: begin op_a = {8'b0, rx_q[47:24]}; op_b = smag; end
			wgo_pkg::MUL_XS_LO: begin op_a = {8'b0, rx_q[23:0]}; op_b = smag; end
			wgo_pkg::MUL_YC_HI: begin op_a = {8'b0, ry_q[47:24]}; op_b = cmag; end
			wgo_pkg::MUL_YC_LO: begin op_a = {8'b0, ry_q[23:0]}; op_b = cmag; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		rnd = prod_q + 64'd32768;
		full = pacc_q + 80'(prod_q);
		qr = full + 80'(1 << 29);
		q = qr[79:30];
		unique case (acc_sel_q)
			wgo_pkg::MUL_XC_LO: begin term_neg = sx_q ^ flip_q ^ x_q[32]; term_to_y = 1'b0; end
			wgo_pkg::MUL_YS_LO: begin
				term_neg = !(sy_q ^ flip_q ^ y_q[32]);
				term_to_y = 1'b0;
			end
			wgo_pkg::MUL_XS_LO: begin term_neg = sx_q ^ flip_q ^ y_q[32]; term_to_y = 1'b1; end
			wgo_pkg::MUL_YC_LO: begin term_neg = sy_q ^ flip_q ^ x_q[32]; term_to_y = 1'b1; end
			default: begin term_neg = 1'b0; term_to_y = 1'b0; end
		endcase
		term = term_neg ? -$signed(53'(q)) : $signed(53'(q));
	end

	always_comb begin
		if (sum_x_q > wgo_pkg::POS_MAX) begin
			sat_x = wgo_pkg::POS_MAX[47:0];
		end else if (sum_x_q < wgo_pkg::POS_MIN) begin
			sat_x = wgo_pkg::POS_MIN[47:0];
		end else begin
			sat_x = sum_x_q[47:0];
		end
		if (sum_y_q > wgo_pkg::POS_MAX) begin
			sat_y = wgo_pkg::POS_MAX[47:0];
		end else if (sum_y_q < wgo_pkg::POS_MIN) begin
			sat_y = wgo_pkg::POS_MIN[47:0];
		end else begin
			sat_y = sum_y_q[47:0];
		end
		nx = world_x_q;
		ny = world_y_q;
		nh = head_q;
		unique case (op_q)
			wgo_pkg::OP_UPDATE: begin nx = sat_x; ny = sat_y; nh = hd_q; end
			wgo_pkg::OP_SET: begin nx = setx_q; ny = sety_q; end
			wgo_pkg::OP_HEADING: begin nh = hd_q; end
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			scale_x_q <= '0;
			scale_y_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			world_x_q <= '0;
			world_y_q <= '0;
			head_q <= '0;
			acc_en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					wgo_pkg::CFG_OFFSET: offset_q <= cfg_data[15:0];
					wgo_pkg::CFG_SCALE_X: scale_x_q <= cfg_data;
					wgo_pkg::CFG_SCALE_Y: scale_y_q <= cfg_data;
					default: begin end
				endcase
			end
			acc_en_q <= cmd.mul_en;
			if (cmd.commit) begin
				world_x_q <= nx;
				world_y_q <= ny;
				head_q <= nh;
				if (op_q == wgo_pkg::OP_UPDATE) begin
					last_x_q <= cx_q;
					last_y_q <= cy_q;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {nh, ny, nx};
		end
		if (cmd.load) begin
			op_q <= s_tuser;
			cx_q <= in_cx;
			cy_q <= in_cy;
			setx_q <= in_setx;
			sety_q <= in_sety;
			hd_q <= hsat;
			mx_q <= diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
			my_q <= diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
			sx_q <= diff_x[32];
			sy_q <= diff_y[32];
			x_q <= wgo_pkg::GAIN_Q30;
			y_q <= '0;
			z_q <= z3;
			flip_q <= flip0;
			sum_x_q <= 53'(world_x_q);
			sum_y_q <= 53'(world_y_q);
		end
		if (cmd.cordic_en) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
		acc_sel_q <= cmd.mul_sel;
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (acc_en_q) begin
			unique case (acc_sel_q)
				wgo_pkg::MUL_TX: rx_q <= rnd[63:16];
				wgo_pkg::MUL_TY: ry_q <= rnd[63:16];
				wgo_pkg::MUL_XC_HI, wgo_pkg::MUL_YS_HI,
				wgo_pkg::MUL_XS_HI, wgo_pkg::MUL_YC_HI: pacc_q <= 80'(prod_q) << 24;
				default: begin
					if (term_to_y) begin
						sum_y_q <= sum_y_q + term;
					end else begin
						sum_x_q <= sum_x_q + term;
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/core/wheel_gyro_odometry.sv @@
// Top level of the wheel and gyro dead-reckoning odometry block.
// A full update runs one CORDIC step a cycle and then eight 32x32 partial products
// on one multiplier before its result is given.
// Other operations skip the CORDIC and the partial products.
// A new request can be taken in the cycle after the result is loaded into the output register.
// Reset clears the position, heading, stored counts and configuration registers to zero.
module wheel_gyro_odometry #(
	parameter int CORDIC_STEPS = wgo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// count_x, count_y, imu_angle, set_x, set_y
	input  logic [wgo_pkg::IN_DATA_W-1:0]         s_tdata,
	// operation
	input  logic [wgo_pkg::OP_W-1:0]              s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pos_x, pos_y, heading
	output logic [wgo_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wgo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wgo_pkg::CFG_DATA_W-1:0]        cfg_data
);

	wgo_pkg::wgo_cmd_t cmd;
	wgo_pkg::wgo_stat_t stat;

	assign cfg_ready = 1'b1;

	wgo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	wgo_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.cmd(cmd),
		.stat(stat)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in progress");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("result committed over a waiting result");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

endmodule
